// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, clocked on clk_i and held off
// while rst_ni is low. Defining NO_ASSERTIONS turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(name, prop, msg)
`define ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== sv/rbki_pkg.sv =====
// ----------------------------------------------------------------------------
// Rigid body integrator package
// Beat types, command and register codes, sizes and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rbki_pkg;

  localparam int AXES      = 3;
  localparam int DATA_W    = 32;
  localparam int DT_W      = 16;
  localparam int DIV_W     = DATA_W + DT_W;
  localparam int DIV_STEPS = DIV_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 3;

  localparam logic [DATA_W-1:0] MASS_RESET = 32'h0001_0000;
  localparam logic [DATA_W-1:0] POS_LIMIT  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_LIMIT  = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_FORCE   = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BODY_MASS   = 3'd0,
    REG_START_POS_X = 3'd1,
    REG_START_POS_Y = 3'd2,
    REG_START_POS_Z = 3'd3,
    REG_START_VEL_X = 3'd4,
    REG_START_VEL_Y = 3'd5,
    REG_START_VEL_Z = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] force_z;
    logic [DT_W-1:0]          delta_time;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] position_x;
    logic signed [DATA_W-1:0] position_y;
    logic signed [DATA_W-1:0] position_z;
    logic signed [DATA_W-1:0] velocity_x;
    logic signed [DATA_W-1:0] velocity_y;
    logic signed [DATA_W-1:0] velocity_z;
    logic                     saturated;
  } out_t;

  function automatic logic clip_hit(input logic signed [DATA_W+1:0] x);
    clip_hit = !((x[DATA_W+1:DATA_W-1] == 3'b000) || (x[DATA_W+1:DATA_W-1] == 3'b111));
  endfunction

  function automatic logic signed [DATA_W-1:0] clip_s32(input logic signed [DATA_W+1:0] x);
    if (clip_hit(x)) begin
      clip_s32 = x[DATA_W+1] ? NEG_LIMIT : POS_LIMIT;
    end else begin
      clip_s32 = x[DATA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/rigid_body_kinematic_integrator.sv =====
// ----------------------------------------------------------------------------
// Rigid body kinematic integrator
// Keeps position, velocity and acceleration of one body on three axes in
// signed Q16.16 and updates them with bit-serial divide and multiply lanes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one command beat (apply force, time step, restart)
// when in_valid_i is high and in_stall_o is low. Each beat yields exactly one
// result beat with the position and velocity after the command and a flag
// that is set when any sum or quotient clipped.
// Apply force runs a restoring divider, one quotient bit per cycle on all
// three axes in parallel: 48 steps, then the quotient is saturated. A time
// step first squares dt and forms v*dt and a*dt one dt bit per cycle
// (16 steps), then forms a*dt^2 one bit per cycle (32 steps). Restart and
// the unused code go straight to the commit state. Every command then
// passes the commit and output states. One command is in flight at a time;
// the next beat is taken in the cycle after the result has been registered.
// The result register holds its beat while out_stall_i is high; a finished
// command waits in its last state until the register is free.
// Reset loads the start values (zero), clears acceleration and sets the
// mass to 1.0. Configuration writes are always ready and should be issued
// only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rigid_body_kinematic_integrator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rbki_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rbki_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rbki_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rbki_pkg::DATA_W-1:0]         cfg_data_i
);

  localparam int Axes  = rbki_pkg::AXES;
  localparam int DataW = rbki_pkg::DATA_W;
  localparam int DtW   = rbki_pkg::DT_W;
  localparam int DivW  = rbki_pkg::DIV_W;
  localparam int StepW = rbki_pkg::STEP_W;

  localparam logic [StepW-1:0] DivLast  = StepW'(rbki_pkg::DIV_STEPS - 1);
  localparam logic [StepW-1:0] MulaLast = StepW'(DtW - 1);
  localparam logic [StepW-1:0] MulbLast = StepW'(2 * DtW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_QSAT,
    ST_MULA,
    ST_MULB,
    ST_COMMIT,
    ST_OUT
  } state_e;

  state_e                    state_q, state_d;
  logic [StepW-1:0]          step_q, step_d;
  logic [1:0]                cmd_q, cmd_d;
  logic [DtW-1:0]            dt_q, dt_d;
  logic [2*DtW-1:0]          sh_q, sh_d;
  logic                      sat_q, sat_d;
  logic                      out_valid_q, out_valid_d;
  rbki_pkg::out_t            out_q, out_d;

  logic [DataW-1:0]          mass_q, mass_d;
  logic signed [DataW-1:0]   spos_q [Axes];
  logic signed [DataW-1:0]   spos_d [Axes];
  logic signed [DataW-1:0]   svel_q [Axes];
  logic signed [DataW-1:0]   svel_d [Axes];

  logic signed [DataW-1:0]   pos_q [Axes];
  logic signed [DataW-1:0]   pos_d [Axes];
  logic signed [DataW-1:0]   vel_q [Axes];
  logic signed [DataW-1:0]   vel_d [Axes];
  logic signed [DataW-1:0]   acc_q [Axes];
  logic signed [DataW-1:0]   acc_d [Axes];

  logic signed [DataW-1:0]   hv_q [Axes];
  logic signed [DataW-1:0]   hv_d [Axes];
  logic signed [DataW-1:0]   ha_q [Axes];
  logic signed [DataW-1:0]   ha_d [Axes];
  logic signed [DataW-1:0]   hb_q [Axes];
  logic signed [DataW-1:0]   hb_d [Axes];

  logic [DataW-1:0]          rem_q [Axes];
  logic [DataW-1:0]          rem_d [Axes];
  logic [DivW-1:0]           dq_q [Axes];
  logic [DivW-1:0]           dq_d [Axes];
  logic                      neg_q [Axes];
  logic                      neg_d [Axes];
  logic                      fz_q [Axes];
  logic                      fz_d [Axes];
  logic signed [DataW:0]     qs_q [Axes];
  logic signed [DataW:0]     qs_d [Axes];

  logic signed [DataW-1:0]   frc [Axes];
  logic [DataW-1:0]          frc_abs [Axes];
  logic [DataW:0]            trial [Axes];
  logic [DataW:0]            diff [Axes];
  logic                      ge [Axes];
  logic                      over [Axes];
  logic [DataW-1:0]          qmag [Axes];
  logic signed [DataW:0]     sum_v [Axes];
  logic signed [DataW:0]     sum_a [Axes];
  logic signed [DataW:0]     sum_b [Axes];
  logic signed [DataW+1:0]   new_pos [Axes];
  logic signed [DataW+1:0]   new_vel [Axes];
  logic signed [DataW+1:0]   new_acc [Axes];
  logic [DtW:0]              sum_dt;
  logic                      mul_bit;
  logic                      in_fire;
  logic                      cfg_fire;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign frc[0] = in_data_i.force_x;
  assign frc[1] = in_data_i.force_y;
  assign frc[2] = in_data_i.force_z;

  assign mul_bit = sh_q[0];
  assign sum_dt  = {1'b0, sh_q[2*DtW-1:DtW]} + (mul_bit ? {1'b0, dt_q} : '0);

  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      frc_abs[i] = frc[i][DataW-1] ? (~frc[i] + DataW'(1)) : frc[i];

      trial[i] = {rem_q[i], dq_q[i][DivW-1]};
      diff[i]  = trial[i] - {1'b0, mass_q};
      ge[i]    = (trial[i] >= {1'b0, mass_q});

      over[i] = !fz_q[i] && ((|dq_q[i][DivW-1:DataW]) ||
                (neg_q[i] ? (dq_q[i][DataW-1] && (|dq_q[i][DataW-2:0]))
                          : dq_q[i][DataW-1]));
      if (fz_q[i]) begin
        qmag[i] = '0;
      end else if (over[i]) begin
        qmag[i] = neg_q[i] ? rbki_pkg::NEG_LIMIT : rbki_pkg::POS_LIMIT;
      end else begin
        qmag[i] = dq_q[i][DataW-1:0];
      end

      sum_v[i] = {hv_q[i][DataW-1], hv_q[i]} +
                 (mul_bit ? {vel_q[i][DataW-1], vel_q[i]} : '0);
      sum_a[i] = {ha_q[i][DataW-1], ha_q[i]} +
                 (mul_bit ? {acc_q[i][DataW-1], acc_q[i]} : '0);
      sum_b[i] = {hb_q[i][DataW-1], hb_q[i]} +
                 (mul_bit ? {acc_q[i][DataW-1], acc_q[i]} : '0);

      new_pos[i] = {{2{pos_q[i][DataW-1]}}, pos_q[i]} +
                   {{2{hv_q[i][DataW-1]}}, hv_q[i]} +
                   {{3{hb_q[i][DataW-1]}}, hb_q[i][DataW-1:1]};
      new_vel[i] = {{2{vel_q[i][DataW-1]}}, vel_q[i]} +
                   {{2{ha_q[i][DataW-1]}}, ha_q[i]};
      new_acc[i] = {{2{acc_q[i][DataW-1]}}, acc_q[i]} +
                   {qs_q[i][DataW], qs_q[i]};
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_d       = cmd_q;
    dt_d        = dt_q;
    sh_d        = sh_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mass_d      = mass_q;
    for (int i = 0; i < Axes; i++) begin
      spos_d[i] = spos_q[i];
      svel_d[i] = svel_q[i];
      pos_d[i]  = pos_q[i];
      vel_d[i]  = vel_q[i];
      acc_d[i]  = acc_q[i];
      hv_d[i]   = hv_q[i];
      ha_d[i]   = ha_q[i];
      hb_d[i]   = hb_q[i];
      rem_d[i]  = rem_q[i];
      dq_d[i]   = dq_q[i];
      neg_d[i]  = neg_q[i];
      fz_d[i]   = fz_q[i];
      qs_d[i]   = qs_q[i];
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_fire) begin
      case (cfg_index_i)
        rbki_pkg::REG_BODY_MASS:   mass_d    = cfg_data_i;
        rbki_pkg::REG_START_POS_X: spos_d[0] = cfg_data_i;
        rbki_pkg::REG_START_POS_Y: spos_d[1] = cfg_data_i;
        rbki_pkg::REG_START_POS_Z: spos_d[2] = cfg_data_i;
        rbki_pkg::REG_START_VEL_X: svel_d[0] = cfg_data_i;
        rbki_pkg::REG_START_VEL_Y: svel_d[1] = cfg_data_i;
        rbki_pkg::REG_START_VEL_Z: svel_d[2] = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d  = in_data_i.command;
          dt_d   = in_data_i.delta_time;
          sh_d   = {{DtW{1'b0}}, in_data_i.delta_time};
          sat_d  = 1'b0;
          step_d = '0;
          for (int i = 0; i < Axes; i++) begin
            hv_d[i]  = '0;
            ha_d[i]  = '0;
            hb_d[i]  = '0;
            rem_d[i] = '0;
            dq_d[i]  = {frc_abs[i], {DtW{1'b0}}};
            neg_d[i] = frc[i][DataW-1];
            fz_d[i]  = (frc[i] == '0);
          end
          case (in_data_i.command)
            rbki_pkg::CMD_FORCE: state_d = ST_DIV;
            rbki_pkg::CMD_STEP:  state_d = ST_MULA;
            default:             state_d = ST_COMMIT;
          endcase
        end
      end
      ST_DIV: begin
        for (int i = 0; i < Axes; i++) begin
          rem_d[i] = ge[i] ? diff[i][DataW-1:0] : trial[i][DataW-1:0];
          dq_d[i]  = {dq_q[i][DivW-2:0], ge[i]};
        end
        step_d = step_q + StepW'(1);
        if (step_q == DivLast) begin
          step_d  = '0;
          state_d = ST_QSAT;
        end
      end
      ST_QSAT: begin
        for (int i = 0; i < Axes; i++) begin
          qs_d[i] = neg_q[i] ? (~{1'b0, qmag[i]} + (DataW + 1)'(1)) : {1'b0, qmag[i]};
          if (over[i]) begin
            sat_d = 1'b1;
          end
        end
        state_d = ST_COMMIT;
      end
      ST_MULA: begin
        for (int i = 0; i < Axes; i++) begin
          hv_d[i] = sum_v[i][DataW:1];
          ha_d[i] = sum_a[i][DataW:1];
        end
        sh_d   = {sum_dt, sh_q[DtW-1:1]};
        step_d = step_q + StepW'(1);
        if (step_q == MulaLast) begin
          step_d  = '0;
          state_d = ST_MULB;
        end
      end
      ST_MULB: begin
        for (int i = 0; i < Axes; i++) begin
          hb_d[i] = sum_b[i][DataW:1];
        end
        sh_d   = {1'b0, sh_q[2*DtW-1:1]};
        step_d = step_q + StepW'(1);
        if (step_q == MulbLast) begin
          step_d  = '0;
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        case (cmd_q)
          rbki_pkg::CMD_FORCE: begin
            for (int i = 0; i < Axes; i++) begin
              acc_d[i] = rbki_pkg::clip_s32(new_acc[i]);
              if (rbki_pkg::clip_hit(new_acc[i])) begin
                sat_d = 1'b1;
              end
            end
          end
          rbki_pkg::CMD_STEP: begin
            for (int i = 0; i < Axes; i++) begin
              pos_d[i] = rbki_pkg::clip_s32(new_pos[i]);
              vel_d[i] = rbki_pkg::clip_s32(new_vel[i]);
              acc_d[i] = '0;
              if (rbki_pkg::clip_hit(new_pos[i]) || rbki_pkg::clip_hit(new_vel[i])) begin
                sat_d = 1'b1;
              end
            end
          end
          rbki_pkg::CMD_RESTART: begin
            for (int i = 0; i < Axes; i++) begin
              pos_d[i] = spos_q[i];
              vel_d[i] = svel_q[i];
              acc_d[i] = '0;
            end
          end
          default: ;
        endcase
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.position_x = pos_q[0];
          out_d.position_y = pos_q[1];
          out_d.position_z = pos_q[2];
          out_d.velocity_x = vel_q[0];
          out_d.velocity_y = vel_q[1];
          out_d.velocity_z = vel_q[2];
          out_d.saturated  = sat_q;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cmd_q       <= '0;
      dt_q        <= '0;
      sh_q        <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      mass_q      <= rbki_pkg::MASS_RESET;
      for (int i = 0; i < Axes; i++) begin
        spos_q[i] <= '0;
        svel_q[i] <= '0;
        pos_q[i]  <= '0;
        vel_q[i]  <= '0;
        acc_q[i]  <= '0;
        hv_q[i]   <= '0;
        ha_q[i]   <= '0;
        hb_q[i]   <= '0;
        rem_q[i]  <= '0;
        dq_q[i]   <= '0;
        neg_q[i]  <= 1'b0;
        fz_q[i]   <= 1'b0;
        qs_q[i]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cmd_q       <= cmd_d;
      dt_q        <= dt_d;
      sh_q        <= sh_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      mass_q      <= mass_d;
      for (int i = 0; i < Axes; i++) begin
        spos_q[i] <= spos_d[i];
        svel_q[i] <= svel_d[i];
        pos_q[i]  <= pos_d[i];
        vel_q[i]  <= vel_d[i];
        acc_q[i]  <= acc_d[i];
        hv_q[i]   <= hv_d[i];
        ha_q[i]   <= ha_d[i];
        hb_q[i]   <= hb_d[i];
        rem_q[i]  <= rem_d[i];
        dq_q[i]   <= dq_d[i];
        neg_q[i]  <= neg_d[i];
        fz_q[i]   <= fz_d[i];
        qs_q[i]   <= qs_d[i];
      end
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall_o,
               "Accepted beat did not make the block busy.")
  `ASSERT_ALWAYS(a_result_from_out, $rose(out_valid_q) |-> $past(state_q == ST_OUT),
                 "Result appeared outside the output state.")
  `ASSERT_NEXT(a_step_clears_acc, (state_q == ST_COMMIT) && (cmd_q == rbki_pkg::CMD_STEP),
               (acc_q[0] == '0) && (acc_q[1] == '0) && (acc_q[2] == '0),
               "Time step left acceleration nonzero.")
  `ASSERT_NEXT(a_restart_no_sat,
               (state_q == ST_COMMIT) && (cmd_q == rbki_pkg::CMD_RESTART), !sat_q,
               "Restart reported saturation.")

endmodule

`default_nettype wire
